// File: hdl/cip_pkg.sv
package cip_pkg;

  localparam int MAX_DIM         = 4;
  localparam int MAX_LEVELS      = 15;
  localparam int IDX_W           = 61;
  localparam int DIM_W           = 3;
  localparam int LEV_W           = 4;
  localparam int AXIS_W          = 2;
  localparam int COORD_W         = MAX_LEVELS + 2;
  localparam int LINE_W          = MAX_LEVELS + 1;
  localparam int DIGIT_W         = MAX_DIM;
  localparam int ALIGN_W         = MAX_DIM * MAX_LEVELS;
  localparam int SHIFT_W         = $clog2(ALIGN_W + 1);
  localparam int STEPS_PER_STAGE = 4;
  localparam int NUM_STAGES      = (MAX_LEVELS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int WALK_STEPS      = NUM_STAGES * STEPS_PER_STAGE;
  localparam int SEL_W           = $clog2(WALK_STEPS + 1);

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = AXIS_W;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic REG_DIMENSIONS = 1'b0;
  localparam logic REG_LEVELS     = 1'b1;

  localparam logic [DIM_W-1:0] DIM_RESET = 3'd2;
  localparam logic [LEV_W-1:0] LEV_RESET = 4'd10;

  typedef logic [DIM_W-1:0] dim_t;
  typedef logic [LEV_W-1:0] lev_t;

  typedef struct packed {
    logic [MAX_DIM-1:0] uneg;
    logic [MAX_DIM-1:0] vneg;
    logic [AXIS_W-1:0]  exit_axis;
  } node_t;

  // state of one point as it walks down the curve levels
  typedef struct packed {
    logic [ALIGN_W-1:0]                    digits;
    logic [COORD_W-1:0]                    line_coord;
    logic [AXIS_W-1:0]                     entry;
    logic [MAX_DIM-1:0]                    wneg;
    logic [MAX_DIM-1:0][WALK_STEPS-1:0]    pos;
  } walk_t;

  function automatic logic [DIGIT_W-1:0] top_digit(input logic [ALIGN_W-1:0] digits,
                                                   input dim_t n);
    logic [DIGIT_W-1:0] d;
    logic [ALIGN_W-1:0] tmp;
    d = '0;
    for (int k = 1; k <= MAX_DIM; k++) begin
      if (n == DIM_W'(k)) begin
        tmp = digits >> ((MAX_LEVELS - 1) * k);
        d = DIGIT_W'(tmp) & DIGIT_W'((1 << k) - 1);
      end
    end
    return d;
  endfunction

  function automatic logic [ALIGN_W-1:0] shift_digits(input logic [ALIGN_W-1:0] digits,
                                                      input dim_t n);
    logic [ALIGN_W-1:0] r;
    r = digits;
    for (int k = 1; k <= MAX_DIM; k++) begin
      if (n == DIM_W'(k)) begin
        r = digits << k;
      end
    end
    return r;
  endfunction

  // sub-cube node of one digit: sign bits of u and v, exit axis
  function automatic node_t node_of_digit(input logic [DIGIT_W-1:0] digit, input dim_t n);
    node_t nd;
    int nn;
    int full;
    int rem;
    int half;
    int prev;
    int cur;
    int iq;
    int li;
    int u [MAX_DIM];
    int v [MAX_DIM];
    nn   = int'(n);
    full = (1 << nn) - 1;
    rem  = int'(digit);
    li   = 0;
    iq   = 1;
    prev = -1;
    cur  = 1;
    half = 0;
    for (int i = 0; i < MAX_DIM; i++) begin
      u[i] = -1;
      v[i] = -1;
    end
    if (rem == 0) begin
      li = nn - 1;
    end else if (rem == full) begin
      li = nn - 1;
      u[0] = 1;
      v[0] = 1;
      v[nn-1] = 1;
    end else begin
      for (int i = 0; i < MAX_DIM; i++) begin
        if (i < nn) begin
          half = 1 << (nn - 1 - i);
          if (rem >= half) begin
            if (rem == half && rem != 1) begin
              li = i;
              iq = -1;
            end
            rem = rem - half;
            cur = 1;
          end else begin
            cur = -1;
            if (rem == half - 1 && rem != 0) begin
              li = i;
              iq = 1;
            end
          end
          u[i] = -prev * cur;
          v[i] = u[i];
          prev = cur;
        end
      end
      v[li] = v[li] * iq;
      v[nn-1] = -v[nn-1];
    end
    for (int i = 0; i < MAX_DIM; i++) begin
      nd.uneg[i] = (u[i] < 0);
      nd.vneg[i] = (v[i] < 0);
    end
    nd.exit_axis = AXIS_W'(li);
    return nd;
  endfunction

  // one curve level: swap entry axis with axis 0, reflect, record sign bits
  function automatic walk_t walk_step(input walk_t w, input dim_t n);
    walk_t r;
    node_t nd;
    logic [DIGIT_W-1:0] d;
    logic [MAX_DIM-1:0] us;
    logic [MAX_DIM-1:0] vs;
    logic [AXIS_W-1:0] ex;
    r  = w;
    d  = top_digit(w.digits, n);
    nd = node_of_digit(d, n);
    us = nd.uneg;
    vs = nd.vneg;
    us[0]       = nd.uneg[w.entry];
    us[w.entry] = nd.uneg[0];
    vs[0]       = nd.vneg[w.entry];
    vs[w.entry] = nd.vneg[0];
    ex = nd.exit_axis;
    if (ex == '0) begin
      ex = w.entry;
    end else if (ex == w.entry) begin
      ex = '0;
    end
    r.entry = ex;
    for (int i = 0; i < MAX_DIM; i++) begin
      r.pos[i]  = {w.pos[i][WALK_STEPS-2:0], ~(us[i] ^ w.wneg[i])};
      r.wneg[i] = ~(w.wneg[i] ^ vs[i]);
    end
    r.digits = shift_digits(w.digits, n);
    return r;
  endfunction

endpackage

// File: hdl/cip_prep.sv
module cip_prep import cip_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  dim_t             dim,
  input  lev_t             lev,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [IDX_W-1:0] in_idx,
  output logic             dn_valid,
  input  logic             dn_ready,
  output walk_t            dn_walk
);

  logic [IDX_W-1:0]   idx_r;
  logic               idx_valid_r;
  logic               idx_valid_nxt;
  walk_t              walk_r;
  walk_t              walk_nxt;
  logic               walk_valid_r;
  logic               walk_valid_nxt;
  logic               adv;
  logic [SHIFT_W-1:0] lev_x;
  logic [SHIFT_W-1:0] dim_x;
  logic [SHIFT_W-1:0] prod;
  logic [SHIFT_W-1:0] sh;
  logic               at_end;
  logic [LINE_W-1:0]  sat;

  assign adv      = !walk_valid_r || dn_ready;
  assign in_ready = !idx_valid_r || adv;

  always_comb begin
    lev_x  = SHIFT_W'(lev);
    dim_x  = SHIFT_W'(dim);
    prod   = lev_x * dim_x;
    sh     = (SHIFT_W'(MAX_LEVELS) - lev_x) * dim_x;
    // index at or above 2^(levels*dimensions) is the end point
    at_end = |(idx_r >> prod);
    sat    = at_end ? (LINE_W'(1) << lev) : idx_r[LINE_W-1:0];

    walk_nxt            = '0;
    walk_nxt.digits     = at_end ? '1 : (idx_r[ALIGN_W-1:0] << sh);
    walk_nxt.line_coord = COORD_W'({sat, 1'b0}) - (COORD_W'(1) << lev);

    idx_valid_nxt  = in_ready ? in_valid : idx_valid_r;
    walk_valid_nxt = adv ? idx_valid_r : walk_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_valid_r  <= 1'b0;
      walk_valid_r <= 1'b0;
    end else begin
      idx_valid_r  <= idx_valid_nxt;
      walk_valid_r <= walk_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      idx_r <= in_idx;
    end
    if (adv && idx_valid_r) begin
      walk_r <= walk_nxt;
    end
  end

  assign dn_valid = walk_valid_r;
  assign dn_walk  = walk_r;

endmodule

// File: hdl/cip_stage.sv
module cip_stage import cip_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  dim_t  dim,
  input  logic  up_valid,
  output logic  up_ready,
  input  walk_t up_walk,
  output logic  dn_valid,
  input  logic  dn_ready,
  output walk_t dn_walk
);

  walk_t walk_r;
  walk_t walk_nxt;
  logic  valid_r;
  logic  valid_nxt;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    walk_nxt = up_walk;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      walk_nxt = walk_step(walk_nxt, dim);
    end
    valid_nxt = up_ready ? up_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      walk_r <= walk_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_walk  = walk_r;

endmodule

// File: hdl/cip_serializer.sv
module cip_serializer import cip_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dim_t                 dim,
  input  lev_t                 lev,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  walk_t                up_walk,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COORD_W-1:0]   out_coord,
  output logic [AXIS_W-1:0]    out_axis,
  output logic                 out_last
);

  logic [COORD_W-1:0]    coord_r [MAX_DIM];
  logic [COORD_W-1:0]    coord_nxt [MAX_DIM];
  logic [AXIS_W-1:0]     cnt_r;
  logic [AXIS_W-1:0]     cnt_nxt;
  logic                  full_r;
  logic                  full_nxt;
  logic [AXIS_W-1:0]     last_axis;
  logic                  last_beat;
  logic                  take;
  logic                  load;
  logic [SEL_W-1:0]      sel;
  logic [WALK_STEPS-1:0] q;

  assign last_axis = AXIS_W'(dim - DIM_W'(1));
  assign last_beat = (cnt_r == last_axis);
  assign take      = full_r && out_ready;
  assign up_ready  = !full_r || (take && last_beat);
  assign load      = up_valid && up_ready;

  always_comb begin
    sel = SEL_W'(WALK_STEPS) - SEL_W'(lev);
    q   = '0;
    for (int i = 0; i < MAX_DIM; i++) begin
      // keep the sign bits of the real levels, level 0 on top
      q = up_walk.pos[i] >> sel;
      coord_nxt[i] = COORD_W'({q, 1'b0}) - ((COORD_W'(1) << lev) - COORD_W'(1));
    end
    if (dim == DIM_W'(1)) begin
      coord_nxt[0] = up_walk.line_coord;
    end

    cnt_nxt  = cnt_r;
    full_nxt = full_r;
    if (load) begin
      cnt_nxt  = '0;
      full_nxt = 1'b1;
    end else if (take) begin
      if (last_beat) begin
        full_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + AXIS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      full_r <= full_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MAX_DIM; i++) begin
        coord_r[i] <= coord_nxt[i];
      end
    end
  end

  assign out_valid = full_r;
  assign out_coord = coord_r[cnt_r];
  assign out_axis  = cnt_r;
  assign out_last  = last_beat;

endmodule

// File: hdl/curve_index_to_point_core.sv
// channel   dir  tdata (lsb up)            tuser          tlast
// in_       in   curve_index [60:0]        -              -
// out_      out  coordinate [16:0]         axis_number    last coordinate
// cfg_      apb  0x0 dimensions, 0x4 levels
//
// indices enter a 7-register pipeline: input register,
// alignment stage, four level stages of four curve levels each, output buffer
// a new index can enter while earlier ones are still in flight; the output buffer
// sends one coordinate per cycle while out_tready is high, dimensions coordinates per item
// synchronous active-low reset clears the pipeline and sets the registers to their reset values
// a stalled output holds each stage in place back to in_tready

module curve_index_to_point_core import cip_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [60:0] curve_index
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [16:0] coordinate
  output logic [OUT_USER_W-1:0] out_tuser,  // [1:0] axis_number
  output logic                  out_tlast,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  dim_t               dim_r;
  dim_t               dim_nxt;
  lev_t               lev_r;
  lev_t               lev_nxt;
  dim_t               dim_eff;
  lev_t               lev_eff;
  logic               cfg_wr;
  logic               reg_sel;
  walk_t              st_walk  [NUM_STAGES+1];
  logic               st_valid [NUM_STAGES+1];
  logic               st_ready [NUM_STAGES+1];
  logic [COORD_W-1:0] coord;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = cfg_paddr[2];

  always_comb begin
    dim_nxt = dim_r;
    lev_nxt = lev_r;
    if (cfg_wr) begin
      case (reg_sel)
        REG_DIMENSIONS: dim_nxt = cfg_pwdata[DIM_W-1:0];
        REG_LEVELS:     lev_nxt = cfg_pwdata[LEV_W-1:0];
        default: ;
      endcase
    end

    case (reg_sel)
      REG_DIMENSIONS: cfg_prdata = CFG_DATA_W'(dim_r);
      REG_LEVELS:     cfg_prdata = CFG_DATA_W'(lev_r);
      default:        cfg_prdata = '0;
    endcase

    dim_eff = dim_r;
    if (dim_r == '0) begin
      dim_eff = DIM_W'(1);
    end else if (dim_r > DIM_W'(MAX_DIM)) begin
      dim_eff = DIM_W'(MAX_DIM);
    end
    lev_eff = lev_r;
    if (lev_r == '0) begin
      lev_eff = LEV_W'(1);
    end else if (lev_r > LEV_W'(MAX_LEVELS)) begin
      lev_eff = LEV_W'(MAX_LEVELS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= DIM_RESET;
      lev_r <= LEV_RESET;
    end else begin
      dim_r <= dim_nxt;
      lev_r <= lev_nxt;
    end
  end

  cip_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .dim      (dim_eff),
    .lev      (lev_eff),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_idx   (in_tdata[IDX_W-1:0]),
    .dn_valid (st_valid[0]),
    .dn_ready (st_ready[0]),
    .dn_walk  (st_walk[0])
  );

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    cip_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .dim      (dim_eff),
      .up_valid (st_valid[k]),
      .up_ready (st_ready[k]),
      .up_walk  (st_walk[k]),
      .dn_valid (st_valid[k+1]),
      .dn_ready (st_ready[k+1]),
      .dn_walk  (st_walk[k+1])
    );
  end

  cip_serializer u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .dim       (dim_eff),
    .lev       (lev_eff),
    .up_valid  (st_valid[NUM_STAGES]),
    .up_ready  (st_ready[NUM_STAGES]),
    .up_walk   (st_walk[NUM_STAGES]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_coord (coord),
    .out_axis  (out_tuser),
    .out_last  (out_tlast)
  );

  assign out_tdata = OUT_DATA_W'(coord);

endmodule
